// ===== hdl/stack_with_lazy_bottom_increment_top_macros.svh =====
// ----------------------------------------------------------------------------
// Stack with lazy bottom increment: assertion macros
// Same-cycle and next-cycle implication checks on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_LAZY_BOTTOM_INCREMENT_TOP_MACROS_SVH
`define STACK_WITH_LAZY_BOTTOM_INCREMENT_TOP_MACROS_SVH

// check cons in the same cycle as ante
`define SLBI_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slbi assertion failed");

// check cons in the cycle after ante
`define SLBI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slbi assertion failed");

`endif

// ===== hdl/slbi_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack with lazy bottom increment: package
// Payload types, operation and status codes, control interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package slbi_pkg;

	localparam logic [1:0] KIND_PUSH = 2'd0;
	localparam logic [1:0] KIND_POP  = 2'd1;
	localparam logic [1:0] KIND_INC  = 2'd2;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	localparam logic [31:0] POPPED_EMPTY = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] value;
		logic [7:0]         count;
	} req_t;

	typedef struct packed {
		logic signed [31:0] popped;
		logic [1:0]         status;
		logic [7:0]         size;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	typedef struct packed {
		logic issue;
		logic exec;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/slbi_ctrl.sv =====
// ----------------------------------------------------------------------------
// Stack with lazy bottom increment: controller
// Two-state sequencer: issue memory reads, then execute and load the result.
// ----------------------------------------------------------------------------
`default_nettype none

module slbi_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire slbi_pkg::dp_sts_t sts,
	output slbi_pkg::dp_cmd_t     cmd
);

	slbi_pkg::state_t state_q;
	slbi_pkg::state_t state_d;

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		state_d   = state_q;
		case (state_q)
			slbi_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.issue = 1'b1;
					state_d   = slbi_pkg::ST_EXEC;
				end
			end
			slbi_pkg::ST_EXEC: begin
				if (sts.out_free) begin
					cmd.exec = 1'b1;
					state_d  = slbi_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = slbi_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slbi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/slbi_datapath.sv =====
// ----------------------------------------------------------------------------
// Stack with lazy bottom increment: datapath
// Value and pending-add memories, top pending-add register, entry count and
// result register. The top entry's pending add lives in a register; its
// memory slot is written back when a push covers it.
// ----------------------------------------------------------------------------
`default_nettype none

module slbi_datapath #(
	parameter int DEPTH = 128
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire slbi_pkg::req_t    req,
	input  wire slbi_pkg::dp_cmd_t cmd,
	output slbi_pkg::dp_sts_t      sts,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output slbi_pkg::rsp_t         rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > 8) ? CW : 8;

	logic [31:0] val_mem [DEPTH];
	logic [31:0] pend_mem [DEPTH];

	logic [CW-1:0] count_q;
	logic [31:0]   top_add_q;
	logic          rsp_valid_q;
	slbi_pkg::rsp_t rsp_q;

	logic [1:0]    kind_s1;
	logic [31:0]   value_s1;
	logic [AW-1:0] idx_s1;
	logic          inc_top_s1;
	logic          inc_none_s1;
	logic [31:0]   val_rd_s1;
	logic [31:0]   pend_rd_s1;

	logic [LW-1:0] k_ext;
	logic [LW-1:0] c_ext;
	logic [LW-1:0] limit;
	logic [LW-1:0] lim_m1;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m2;
	logic [AW-1:0] val_raddr;
	logic [AW-1:0] pend_raddr;

	logic          empty;
	logic          full;
	logic          val_we;
	logic          pend_we;
	logic [AW-1:0] pend_waddr;
	logic [31:0]   pend_wdata;
	logic [CW-1:0] count_d;
	logic [31:0]   top_add_d;
	slbi_pkg::rsp_t rsp_d;

	always_comb begin
		k_ext      = LW'(req.count);
		c_ext      = LW'(count_q);
		limit      = (k_ext < c_ext) ? k_ext : c_ext;
		lim_m1     = limit - LW'(1);
		cnt_m1     = count_q - CW'(1);
		cnt_m2     = count_q - CW'(2);
		val_raddr  = cnt_m1[AW-1:0];
		pend_raddr = (req.kind == slbi_pkg::KIND_POP) ? cnt_m2[AW-1:0] : lim_m1[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			kind_s1     <= req.kind;
			value_s1    <= req.value;
			idx_s1      <= lim_m1[AW-1:0];
			inc_top_s1  <= (limit == c_ext);
			inc_none_s1 <= (limit == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && val_we) begin
			val_mem[count_q[AW-1:0]] <= value_s1;
		end
		if (cmd.issue) begin
			val_rd_s1 <= val_mem[val_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && pend_we) begin
			pend_mem[pend_waddr] <= pend_wdata;
		end
		if (cmd.issue) begin
			pend_rd_s1 <= pend_mem[pend_raddr];
		end
	end

	always_comb begin
		empty        = (count_q == '0);
		full         = (count_q == CW'(DEPTH));
		val_we       = 1'b0;
		pend_we      = 1'b0;
		pend_waddr   = cnt_m1[AW-1:0];
		pend_wdata   = top_add_q;
		count_d      = count_q;
		top_add_d    = top_add_q;
		rsp_d.popped = '0;
		rsp_d.status = slbi_pkg::STATUS_OK;
		case (kind_s1)
			slbi_pkg::KIND_PUSH: begin
				if (full) begin
					rsp_d.status = slbi_pkg::STATUS_FULL;
				end else begin
					val_we    = 1'b1;
					pend_we   = !empty;
					top_add_d = '0;
					count_d   = count_q + CW'(1);
				end
			end
			slbi_pkg::KIND_POP: begin
				if (empty) begin
					rsp_d.popped = slbi_pkg::POPPED_EMPTY;
					rsp_d.status = slbi_pkg::STATUS_EMPTY;
				end else begin
					rsp_d.popped = val_rd_s1 + top_add_q;
					top_add_d    = (count_q > CW'(1)) ? (pend_rd_s1 + top_add_q) : '0;
					count_d      = cnt_m1;
				end
			end
			slbi_pkg::KIND_INC: begin
				if (!inc_none_s1) begin
					if (inc_top_s1) begin
						top_add_d = top_add_q + value_s1;
					end else begin
						pend_we    = 1'b1;
						pend_waddr = idx_s1;
						pend_wdata = pend_rd_s1 + value_s1;
					end
				end
			end
			default: begin
			end
		endcase
		rsp_d.size = 8'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			top_add_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				count_q     <= count_d;
				top_add_q   <= top_add_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q <= rsp_d;
		end
	end

	assign sts.out_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid    = rsp_valid_q;
	assign rsp          = rsp_q;

endmodule

`default_nettype wire

// ===== hdl/stack_with_lazy_bottom_increment_top.sv =====
// Flow: a request transfer reads both memories into the request stage
// registers; the execute state writes the memories as needed and registers
// the result. A new request is taken only in the idle state. A stalled result
// holds the execute state until the result register frees.
// Reset: entry count and top pending add clear at once; the memories take no
// clearing pass, and the block accepts requests right after reset.
// ----------------------------------------------------------------------------
// Stack with lazy bottom increment: top level
// Bounded stack with push, pop and lazy increment of the bottom entries.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_with_lazy_bottom_increment_top #(
	parameter int DEPTH = 128
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire slbi_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output slbi_pkg::rsp_t      rsp
);

	slbi_pkg::dp_cmd_t cmd;
	slbi_pkg::dp_sts_t sts;

	slbi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	slbi_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ===== hdl/slbi_checker.sv =====
// ----------------------------------------------------------------------------
// Stack with lazy bottom increment: port checker
// Checks handshake and result consistency seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stack_with_lazy_bottom_increment_top_macros.svh"

module slbi_checker #(
	parameter int DEPTH = 128
) (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_ready,
	input wire slbi_pkg::req_t req,
	input wire logic           rsp_valid,
	input wire logic           rsp_ready,
	input wire slbi_pkg::rsp_t rsp
);

	`SLBI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
	`SLBI_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)
	`SLBI_ASSERT_NOW(a_empty_pop, rsp_valid && (rsp.status == slbi_pkg::STATUS_EMPTY), (rsp.popped == slbi_pkg::POPPED_EMPTY) && (rsp.size == 8'd0))
	`SLBI_ASSERT_NOW(a_full_push, rsp_valid && (rsp.status == slbi_pkg::STATUS_FULL), (rsp.popped == 32'sd0) && (rsp.size == 8'(DEPTH)))

endmodule

bind stack_with_lazy_bottom_increment_top slbi_checker #(.DEPTH(DEPTH)) u_checker (.*);

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Stack with lazy bottom increment: testbench
// Drives push, pop, increment and unused-kind requests through valid/ready,
// mirrors the stack and its pending adds, and checks every response field.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 128;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int HOLD_OFF_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	slbi_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready;
	slbi_pkg::rsp_t rsp;

	logic [31:0] mirror_vals [DEPTH];
	logic [31:0] mirror_adds [DEPTH];
	int unsigned mirror_count;

	slbi_pkg::rsp_t expected_rsps [$];
	int mismatch_count = 0;
	int gap_pct = 20;
	bit no_idle = 1'b0;
	bit hold_off_request = 1'b0;

	stack_with_lazy_bottom_increment_top #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #6 clk = ~clk;

	function automatic slbi_pkg::req_t make_op(input logic [1:0] kind,
			input logic [31:0] value, input logic [7:0] count);
		slbi_pkg::req_t op;
		op.kind = kind;
		op.value = value;
		op.count = count;
		return op;
	endfunction

	function automatic slbi_pkg::rsp_t stack_apply(input slbi_pkg::req_t op);
		slbi_pkg::rsp_t res;
		int unsigned top;
		int unsigned lim;
		logic [31:0] add;
		res.popped = '0;
		res.status = slbi_pkg::STATUS_OK;
		case (op.kind)
			slbi_pkg::KIND_PUSH: begin
				if (mirror_count >= DEPTH) begin
					res.status = slbi_pkg::STATUS_FULL;
				end else begin
					mirror_vals[mirror_count] = op.value;
					mirror_adds[mirror_count] = '0;
					mirror_count++;
				end
			end
			slbi_pkg::KIND_POP: begin
				if (mirror_count == 0) begin
					res.popped = slbi_pkg::POPPED_EMPTY;
					res.status = slbi_pkg::STATUS_EMPTY;
				end else begin
					top = mirror_count - 1;
					add = mirror_adds[top];
					res.popped = mirror_vals[top] + add;
					if (top > 0)
						mirror_adds[top - 1] = mirror_adds[top - 1] + add;
					mirror_adds[top] = '0;
					mirror_count = top;
				end
			end
			slbi_pkg::KIND_INC: begin
				lim = (op.count < mirror_count) ? op.count : mirror_count;
				if (lim > 0)
					mirror_adds[lim - 1] = mirror_adds[lim - 1] + op.value;
			end
			default: begin
			end
		endcase
		res.size = 8'(mirror_count);
		return res;
	endfunction

	function automatic void log_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: mismatch: %s", $realtime, msg);
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(0, 20)) - 32'd10;
			default: return $urandom;
		endcase
	endfunction

	function automatic slbi_pkg::req_t pick_op(input int push_pct);
		int unsigned roll;
		logic [7:0] count;
		roll = $urandom_range(1, 100);
		if ($urandom_range(0, 9) == 0)
			count = 8'($urandom_range(0, 255));
		else
			count = 8'($urandom_range(0, mirror_count + 1));
		if (roll <= 3)
			return make_op(KIND_UNUSED, $urandom, 8'($urandom));
		if (roll <= 3 + push_pct)
			return make_op(slbi_pkg::KIND_PUSH, pick_value(), 8'($urandom));
		if (roll <= 3 + push_pct + (100 - push_pct) * 6 / 10)
			return make_op(slbi_pkg::KIND_POP, $urandom, 8'($urandom));
		return make_op(slbi_pkg::KIND_INC, pick_value(), count);
	endfunction

	task automatic send_op(input slbi_pkg::req_t op);
		if (!no_idle && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		expected_rsps.push_back(stack_apply(op));
		req_valid <= 1'b1;
		req <= op;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (expected_rsps.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin : rsp_check
		slbi_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsps.size() == 0) begin
				log_mismatch($sformatf("unexpected response transfer popped=%h status=%0d size=%0d",
					rsp.popped, rsp.status, rsp.size));
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.popped !== want.popped || rsp.status !== want.status
						|| rsp.size !== want.size)
					log_mismatch($sformatf(
						"expected popped=%h status=%0d size=%0d, got popped=%h status=%0d size=%0d",
						want.popped, want.status, want.size, rsp.popped, rsp.status, rsp.size));
			end
		end
	end

	initial begin : rsp_side
		int unsigned stall;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = 0;
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				stall = HOLD_OFF_CYCLES;
			end else if (!no_idle && $urandom_range(0, 2) == 0) begin
				stall = $urandom_range(1, 19);
			end
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			repeat (no_idle ? 1 : $urandom_range(1, 30)) @(posedge clk);
		end
	end

	task automatic test_directed_edges();
		gap_pct = 20;
		send_op(make_op(slbi_pkg::KIND_POP, 32'h0, 8'd0));
		send_op(make_op(slbi_pkg::KIND_INC, 32'd9, 8'd5));
		send_op(make_op(slbi_pkg::KIND_PUSH, 32'h7FFF_FFFF, 8'hFF));
		send_op(make_op(slbi_pkg::KIND_PUSH, 32'h8000_0000, 8'd0));
		send_op(make_op(slbi_pkg::KIND_PUSH, 32'h0000_0000, 8'd0));
		send_op(make_op(slbi_pkg::KIND_PUSH, 32'hFFFF_FFFF, 8'd0));
		send_op(make_op(slbi_pkg::KIND_INC, 32'd7, 8'd0));
		send_op(make_op(slbi_pkg::KIND_INC, 32'd1, 8'd1));
		send_op(make_op(slbi_pkg::KIND_INC, 32'h5555_5555, 8'd255));
		send_op(make_op(slbi_pkg::KIND_INC, 32'hAAAA_AAAA, 8'd2));
		send_op(make_op(slbi_pkg::KIND_INC, 32'hFFFF_FFFD, 8'd128));
		send_op(make_op(KIND_UNUSED, 32'hFFFF_FFFF, 8'hFF));
		send_op(make_op(slbi_pkg::KIND_POP, 32'hFFFF_FFFF, 8'hFF));
		send_op(make_op(slbi_pkg::KIND_PUSH, 32'h1234_5678, 8'd0));
		send_op(make_op(slbi_pkg::KIND_INC, 32'h8000_0000, 8'd3));
		repeat (4) send_op(make_op(slbi_pkg::KIND_POP, 32'h0, 8'd0));
		send_op(make_op(slbi_pkg::KIND_POP, 32'h0, 8'd0));
		send_op(make_op(slbi_pkg::KIND_PUSH, 32'd1, 8'd0));
		send_op(make_op(slbi_pkg::KIND_POP, 32'h0, 8'd0));
		send_op(make_op(slbi_pkg::KIND_INC, 32'h7FFF_FFFF, 8'd127));
		drain_results();
	endtask

	task automatic test_fill_to_depth();
		gap_pct = 15;
		repeat (DEPTH) send_op(make_op(slbi_pkg::KIND_PUSH, pick_value(), 8'($urandom)));
		send_op(make_op(slbi_pkg::KIND_PUSH, 32'h7FFF_FFFF, 8'd0));
		send_op(make_op(slbi_pkg::KIND_PUSH, 32'h8000_0000, 8'd0));
		send_op(make_op(slbi_pkg::KIND_INC, pick_value(), 8'd128));
		send_op(make_op(slbi_pkg::KIND_INC, pick_value(), 8'd200));
		send_op(make_op(slbi_pkg::KIND_INC, pick_value(), 8'd127));
		send_op(make_op(KIND_UNUSED, 32'h0, 8'h80));
		for (int i = 0; i <= DEPTH; i++) begin
			if (i % 16 == 5)
				send_op(make_op(slbi_pkg::KIND_INC, pick_value(),
					8'($urandom_range(1, 255))));
			send_op(make_op(slbi_pkg::KIND_POP, $urandom, 8'($urandom)));
		end
		drain_results();
	endtask

	task automatic test_output_hold_off();
		gap_pct = 0;
		hold_off_request = 1'b1;
		repeat (40) send_op(pick_op(60));
		drain_results();
	endtask

	task automatic test_random_mix();
		int push_pct;
		for (int blk = 0; blk < 11; blk++) begin
			case ($urandom_range(0, 3))
				0: push_pct = 20;
				1: push_pct = 45;
				2: push_pct = 70;
				default: push_pct = 90;
			endcase
			gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
			repeat (50) send_op(pick_op(push_pct));
			if (blk == 5)
				drain_results();
		end
		drain_results();
	endtask

	task automatic test_steady_tail();
		no_idle = 1'b1;
		repeat (100) send_op(pick_op(50));
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		mirror_count = 0;
		foreach (mirror_adds[i]) begin
			mirror_adds[i] = '0;
			mirror_vals[i] = '0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_fill_to_depth();
		test_output_hold_off();
		test_random_mix();
		test_steady_tail();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_rsps.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
